// File: hw/rtl/rpn_pkg.sv
// rpn_pkg: shared constants, codes and control structs of the rpn stack calculator
// no dependencies; imported by every rtl file of the block

package rpn_pkg;

  // sizes
  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int OP_W        = 4;
  localparam int KIND_W      = 2;
  localparam int ERR_W       = 4;
  localparam int DEPTH_OUT_W = 6;

  // command codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 4'd0,
    OP_POP   = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_DUP   = 4'd6,
    OP_SWAP  = 4'd7,
    OP_ROLL  = 4'd8,
    OP_CLEAR = 4'd9,
    OP_PRINT = 4'd10
  } opcode_e;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DONE  = 2'd0,
    KIND_ELEM  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  // error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE         = 4'd0,
    ERR_POP_EMPTY    = 4'd1,
    ERR_FEW_OPERANDS = 4'd2,
    ERR_DIV_ZERO     = 4'd3,
    ERR_DUP_EMPTY    = 4'd4,
    ERR_SWAP_FEW     = 4'd5,
    ERR_BAD_ROLL     = 4'd6,
    ERR_INVALID      = 4'd7,
    ERR_FULL         = 4'd8
  } err_e;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_RD_B,
    S_RD_A,
    S_EXEC,
    S_DIV_WAIT,
    S_WRITE_RES,
    S_DUP_WR,
    S_SWAP_W1,
    S_SWAP_W2,
    S_ROLL_MV,
    S_ROLL_CAP,
    S_ROLL_WR,
    S_ROLL_RD,
    S_ROLL_LAST,
    S_PRINT_RD,
    S_PRINT_EMIT,
    S_EMIT
  } state_e;

  // stack read address select
  typedef enum logic [2:0] {
    RD_NONE,
    RD_TOP,
    RD_SECOND,
    RD_PTR,
    RD_PTR_NEXT
  } rd_sel_e;

  // stack write select
  typedef enum logic [2:0] {
    WR_NONE,
    WR_PUSH,
    WR_DUP,
    WR_RES,
    WR_SWAP_TOP,
    WR_SWAP_SECOND,
    WR_ROLL_SHIFT,
    WR_ROLL_LAST
  } wr_sel_e;

  typedef enum logic [1:0] {
    DEPTH_HOLD,
    DEPTH_INC,
    DEPTH_DEC,
    DEPTH_CLEAR
  } depth_op_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ROLL,
    PTR_TOP,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  // controller to datapath
  typedef struct packed {
    logic      latch_in;
    rd_sel_e   rd_sel;
    wr_sel_e   wr_sel;
    depth_op_e depth_op;
    ptr_op_e   ptr_op;
    logic      cap_b;
    logic      cap_a;
    logic      cap_moved;
    logic      alu_go;
    logic      div_start;
    logic      div_load;
    logic      set_result;
    kind_e     res_kind;
    err_e      res_err;
    logic      emit_result;
    logic      emit_elem;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_e op;
    logic    halted;
    logic    depth_zero;
    logic    depth_lt2;
    logic    depth_full;
    logic    b_zero;
    logic    roll_one;
    logic    roll_bad;
    logic    roll_more;
    logic    ptr_zero;
    logic    div_done;
    logic    out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/rpn_div.sv
// rpn_div: iterative signed divider, one quotient bit per cycle, truncating toward zero
// depends on rpn_pkg

module rpn_div
  import rpn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o
);

  localparam int DCNT_W = $clog2(DATA_W + 1);

  logic [DCNT_W-1:0] cnt_q;
  logic              done_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] mag_b_q;
  logic              neg_q;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;

  // restoring step on magnitudes
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign trial   = shifted - {1'b0, mag_b_q};

  // iteration counter and done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DCNT_W'(DATA_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - DCNT_W'(1);
        if (cnt_q == DCNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= '0;
      quo_q   <= dividend_i[DATA_W-1] ? (DATA_W'(0) - dividend_i) : dividend_i;
      mag_b_q <= divisor_i[DATA_W-1] ? (DATA_W'(0) - divisor_i) : divisor_i;
      neg_q   <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
    end else if (cnt_q != '0) begin
      if (!trial[DATA_W]) begin
        rem_q <= trial[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  // sign correction
  assign quotient_o = neg_q ? (DATA_W'(0) - quo_q) : quo_q;
  assign done_o     = done_q;

endmodule

// File: hw/rtl/rpn_datapath.sv
// rpn_datapath: stack memory, depth and halt flags, alu, divider and result register
// depends on rpn_pkg and rpn_div

module rpn_datapath
  import rpn_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_status_t             status_o,
  input  logic [OP_W-1:0]        opcode_i,
  input  logic [DATA_W-1:0]      operand_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [KIND_W-1:0]      kind_o,
  output logic [DATA_W-1:0]      data_o,
  output logic [ERR_W-1:0]       error_code_o,
  output logic [DEPTH_OUT_W-1:0] depth_o,
  output logic                   last_o
);

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] arg_q;
  logic [CNT_W-1:0]  depth_q, depth_d;
  logic              halted_q, halted_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] b_q;
  logic [DATA_W-1:0] res_q;
  logic [DATA_W-1:0] moved_q;
  kind_e             kind_q;
  err_e              err_q;

  logic                   out_valid_q;
  logic [KIND_W-1:0]      out_kind_q;
  logic [DATA_W-1:0]      out_data_q;
  logic [ERR_W-1:0]       out_err_q;
  logic [DEPTH_OUT_W-1:0] out_depth_q;
  logic                   out_last_q;

  logic [CNT_W-1:0]  depth_m1, depth_m2, roll_pos, ptr_next;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [DATA_W-1:0] wdata;
  logic              out_free;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;

  // address arithmetic
  assign depth_m1 = depth_q - CNT_W'(1);
  assign depth_m2 = depth_q - CNT_W'(2);
  assign roll_pos = depth_q - arg_q[CNT_W-1:0];
  assign ptr_next = CNT_W'(ptr_q) + CNT_W'(1);
  assign out_free = !out_valid_q || out_ready_i;

  // status flags
  always_comb begin
    status_o            = '0;
    status_o.op         = opcode_e'(op_q);
    status_o.halted     = halted_q;
    status_o.depth_zero = (depth_q == '0);
    status_o.depth_lt2  = (depth_q < CNT_W'(2));
    status_o.depth_full = (depth_q >= CNT_W'(STACK_DEPTH));
    status_o.b_zero     = (b_q == '0);
    status_o.roll_one   = (arg_q == DATA_W'(1));
    status_o.roll_bad   = arg_q[DATA_W-1] || (arg_q == '0) || (arg_q > DATA_W'(depth_q));
    status_o.roll_more  = (ptr_next < depth_q);
    status_o.ptr_zero   = (ptr_q == '0);
    status_o.div_done   = div_done;
    status_o.out_free   = out_free;
  end

  // read port select
  always_comb begin
    rd_en = 1'b1;
    raddr = '0;
    case (cmd_i.rd_sel)
      RD_TOP:      raddr = depth_m1[ADDR_W-1:0];
      RD_SECOND:   raddr = depth_m2[ADDR_W-1:0];
      RD_PTR:      raddr = ptr_q;
      RD_PTR_NEXT: raddr = ptr_next[ADDR_W-1:0];
      default:     rd_en = 1'b0;
    endcase
  end

  // write port select
  always_comb begin
    wr_en = 1'b1;
    waddr = '0;
    wdata = '0;
    case (cmd_i.wr_sel)
      WR_PUSH: begin
        waddr = depth_q[ADDR_W-1:0];
        wdata = arg_q;
      end
      WR_DUP: begin
        waddr = depth_q[ADDR_W-1:0];
        wdata = rdata_q;
      end
      WR_RES: begin
        waddr = depth_m2[ADDR_W-1:0];
        wdata = res_q;
      end
      WR_SWAP_TOP: begin
        waddr = depth_m1[ADDR_W-1:0];
        wdata = a_q;
      end
      WR_SWAP_SECOND: begin
        waddr = depth_m2[ADDR_W-1:0];
        wdata = b_q;
      end
      WR_ROLL_SHIFT: begin
        waddr = ptr_q;
        wdata = rdata_q;
      end
      WR_ROLL_LAST: begin
        waddr = depth_m1[ADDR_W-1:0];
        wdata = moved_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // stack memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= stack_mem[raddr];
    end
  end

  // next depth, pointer and halt flag
  always_comb begin
    depth_d = depth_q;
    case (cmd_i.depth_op)
      DEPTH_INC:   depth_d = depth_q + CNT_W'(1);
      DEPTH_DEC:   depth_d = depth_m1;
      DEPTH_CLEAR: depth_d = '0;
      default:     depth_d = depth_q;
    endcase
  end

  always_comb begin
    ptr_d = ptr_q;
    case (cmd_i.ptr_op)
      PTR_ROLL: ptr_d = roll_pos[ADDR_W-1:0];
      PTR_TOP:  ptr_d = depth_m1[ADDR_W-1:0];
      PTR_INC:  ptr_d = ptr_next[ADDR_W-1:0];
      PTR_DEC:  ptr_d = ptr_q - ADDR_W'(1);
      default:  ptr_d = ptr_q;
    endcase
  end

  assign halted_d = halted_q || (cmd_i.emit_result && (kind_q == KIND_ERROR));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      halted_q <= 1'b0;
      ptr_q    <= '0;
    end else begin
      depth_q  <= depth_d;
      halted_q <= halted_d;
      ptr_q    <= ptr_d;
    end
  end

  // command, operand and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q  <= opcode_i;
      arg_q <= operand_i;
    end
    if (cmd_i.cap_b) begin
      b_q <= rdata_q;
    end
    if (cmd_i.cap_a) begin
      a_q <= rdata_q;
    end
    if (cmd_i.cap_moved) begin
      moved_q <= rdata_q;
    end
    if (cmd_i.set_result) begin
      kind_q <= cmd_i.res_kind;
      err_q  <= cmd_i.res_err;
    end
    if (cmd_i.div_load) begin
      res_q <= div_quo;
    end else if (cmd_i.alu_go) begin
      case (opcode_e'(op_q))
        OP_ADD:  res_q <= a_q + b_q;
        OP_SUB:  res_q <= a_q - b_q;
        OP_MUL:  res_q <= a_q * b_q;
        default: res_q <= a_q;
      endcase
    end
  end

  // divider for DIV
  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // result register, holds until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_result || cmd_i.emit_elem) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_result) begin
      out_kind_q  <= kind_q;
      out_data_q  <= '0;
      out_err_q   <= err_q;
      out_depth_q <= DEPTH_OUT_W'(depth_q);
      out_last_q  <= 1'b1;
    end else if (cmd_i.emit_elem) begin
      out_kind_q  <= KIND_ELEM;
      out_data_q  <= rdata_q;
      out_err_q   <= ERR_NONE;
      out_depth_q <= DEPTH_OUT_W'(depth_q);
      out_last_q  <= (ptr_q == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign data_o       = out_data_q;
  assign error_code_o = out_err_q;
  assign depth_o      = out_depth_q;
  assign last_o       = out_last_q;

endmodule

// File: hw/rtl/rpn_ctrl.sv
// rpn_ctrl: command sequencer of the rpn stack calculator
// depends on rpn_pkg; drives rpn_datapath through dp_cmd_t

module rpn_ctrl
  import rpn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        state_d = S_EMIT;
        if (!status_i.halted) begin
          case (status_i.op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: begin
              if (!status_i.depth_lt2) state_d = S_RD_B;
            end
            OP_DUP: begin
              if (!status_i.depth_zero && !status_i.depth_full) state_d = S_DUP_WR;
            end
            OP_ROLL: begin
              if (!status_i.roll_one && !status_i.roll_bad) state_d = S_ROLL_MV;
            end
            OP_PRINT: begin
              if (!status_i.depth_zero) state_d = S_PRINT_RD;
            end
            default: state_d = S_EMIT;
          endcase
        end
      end
      S_RD_B:      state_d = S_RD_A;
      S_RD_A:      state_d = (status_i.op == OP_SWAP) ? S_SWAP_W1 : S_EXEC;
      S_EXEC: begin
        if (status_i.op != OP_DIV) begin
          state_d = S_WRITE_RES;
        end else if (status_i.b_zero) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (status_i.div_done) state_d = S_WRITE_RES;
      end
      S_WRITE_RES: state_d = S_EMIT;
      S_DUP_WR:    state_d = S_EMIT;
      S_SWAP_W1:   state_d = S_SWAP_W2;
      S_SWAP_W2:   state_d = S_EMIT;
      S_ROLL_MV:   state_d = S_ROLL_CAP;
      S_ROLL_CAP, S_ROLL_RD: begin
        state_d = status_i.roll_more ? S_ROLL_WR : S_ROLL_LAST;
      end
      S_ROLL_WR:   state_d = S_ROLL_RD;
      S_ROLL_LAST: state_d = S_EMIT;
      S_PRINT_RD:  state_d = S_PRINT_EMIT;
      S_PRINT_EMIT: begin
        if (status_i.out_free) state_d = status_i.ptr_zero ? S_IDLE : S_PRINT_RD;
      end
      S_EMIT: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o    = '0;
    cmd_o.res_kind = KIND_DONE;
    cmd_o.res_err  = ERR_NONE;
    case (state_q)
      S_IDLE: begin
        cmd_o.latch_in = in_valid_i;
      end
      S_DECODE: begin
        cmd_o.set_result = 1'b1;
        if (status_i.halted) begin
          cmd_o.res_kind = KIND_ERROR;
          cmd_o.res_err  = ERR_FULL;
        end else begin
          case (status_i.op)
            OP_PUSH: begin
              if (status_i.depth_full) begin
                cmd_o.res_kind = KIND_ERROR;
                cmd_o.res_err  = ERR_FULL;
              end else begin
                cmd_o.wr_sel   = WR_PUSH;
                cmd_o.depth_op = DEPTH_INC;
              end
            end
            OP_POP: begin
              if (status_i.depth_zero) begin
                cmd_o.res_kind = KIND_ERROR;
                cmd_o.res_err  = ERR_POP_EMPTY;
              end else begin
                cmd_o.depth_op = DEPTH_DEC;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (status_i.depth_lt2) begin
                cmd_o.res_kind = KIND_ERROR;
                cmd_o.res_err  = ERR_FEW_OPERANDS;
              end else begin
                cmd_o.rd_sel = RD_TOP;
              end
            end
            OP_SWAP: begin
              if (status_i.depth_lt2) begin
                cmd_o.res_kind = KIND_ERROR;
                cmd_o.res_err  = ERR_SWAP_FEW;
              end else begin
                cmd_o.rd_sel = RD_TOP;
              end
            end
            OP_DUP: begin
              if (status_i.depth_zero) begin
                cmd_o.res_kind = KIND_ERROR;
                cmd_o.res_err  = ERR_DUP_EMPTY;
              end else if (status_i.depth_full) begin
                cmd_o.res_kind = KIND_ERROR;
                cmd_o.res_err  = ERR_FULL;
              end else begin
                cmd_o.rd_sel = RD_TOP;
              end
            end
            OP_ROLL: begin
              if (!status_i.roll_one && status_i.roll_bad) begin
                cmd_o.res_kind = KIND_ERROR;
                cmd_o.res_err  = ERR_BAD_ROLL;
              end else if (!status_i.roll_one) begin
                cmd_o.ptr_op = PTR_ROLL;
              end
            end
            OP_CLEAR: begin
              cmd_o.depth_op = DEPTH_CLEAR;
            end
            OP_PRINT: begin
              if (status_i.depth_zero) begin
                cmd_o.res_kind = KIND_EMPTY;
              end else begin
                cmd_o.ptr_op = PTR_TOP;
              end
            end
            default: begin
              cmd_o.res_kind = KIND_ERROR;
              cmd_o.res_err  = ERR_INVALID;
            end
          endcase
        end
      end
      // operand fetch: top first, then the one below it
      S_RD_B: begin
        cmd_o.cap_b  = 1'b1;
        cmd_o.rd_sel = RD_SECOND;
      end
      S_RD_A: begin
        cmd_o.cap_a = 1'b1;
      end
      S_EXEC: begin
        if (status_i.op != OP_DIV) begin
          cmd_o.alu_go = 1'b1;
        end else if (status_i.b_zero) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_kind   = KIND_ERROR;
          cmd_o.res_err    = ERR_DIV_ZERO;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      S_DIV_WAIT: begin
        cmd_o.div_load = status_i.div_done;
      end
      S_WRITE_RES: begin
        cmd_o.wr_sel   = WR_RES;
        cmd_o.depth_op = DEPTH_DEC;
      end
      S_DUP_WR: begin
        cmd_o.wr_sel   = WR_DUP;
        cmd_o.depth_op = DEPTH_INC;
      end
      S_SWAP_W1: begin
        cmd_o.wr_sel = WR_SWAP_TOP;
      end
      S_SWAP_W2: begin
        cmd_o.wr_sel = WR_SWAP_SECOND;
      end
      // roll: fetch the moved word once, then shift the rest down one place
      S_ROLL_MV: begin
        cmd_o.rd_sel = RD_PTR;
      end
      S_ROLL_CAP: begin
        cmd_o.cap_moved = 1'b1;
        if (status_i.roll_more) cmd_o.rd_sel = RD_PTR_NEXT;
      end
      S_ROLL_WR: begin
        cmd_o.wr_sel = WR_ROLL_SHIFT;
        cmd_o.ptr_op = PTR_INC;
      end
      S_ROLL_RD: begin
        if (status_i.roll_more) cmd_o.rd_sel = RD_PTR_NEXT;
      end
      S_ROLL_LAST: begin
        cmd_o.wr_sel = WR_ROLL_LAST;
      end
      // print walks from the top down
      S_PRINT_RD: begin
        cmd_o.rd_sel = RD_PTR;
      end
      S_PRINT_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_elem = 1'b1;
          if (!status_i.ptr_zero) cmd_o.ptr_op = PTR_DEC;
        end
      end
      S_EMIT: begin
        cmd_o.emit_result = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// File: hw/rtl/rpn_stack_calculator.sv
// rpn_stack_calculator: top level of the rpn stack calculator
// depends on rpn_pkg, rpn_ctrl, rpn_datapath and rpn_div
//
// Usage
//   Input channel (in_valid_i/in_ready_o) carries one command per transaction:
//   opcode_i and operand_i. Output channel (out_valid_o/out_ready_i) carries
//   result transactions: kind_o, data_o, error_code_o, depth_o and last_o.
//   Every command gives one result, PRINT gives one per stack entry (top first,
//   last_o on the bottom one) or a single empty marker.
//   Commands run one at a time; in_ready_o is high whenever the sequencer is
//   idle, even while the previous result waits in the output register.
//   Command timing is set by the stack memory with its registered read port and
//   the serial divider: DIV makes one quotient bit a cycle, and ROLL makes one
//   memory read and one write per shifted word.
//   A stalled receiver holds the output register and the sequencer waits
//   before writing the next result into it.
//   Reset empties the stack and clears the halt flag; the stack memory itself
//   is not cleared. After any error every command returns error code 8.

module rpn_stack_calculator
  import rpn_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [OP_W-1:0]               opcode_i,
  input  logic signed [DATA_W-1:0]      operand_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [KIND_W-1:0]             kind_o,
  output logic signed [DATA_W-1:0]      data_o,
  output logic [ERR_W-1:0]              error_code_o,
  output logic [DEPTH_OUT_W-1:0]        depth_o,
  output logic                          last_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [DATA_W-1:0] data_u;

  // sequencer
  rpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // stack, arithmetic and result register
  rpn_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .opcode_i     (opcode_i),
    .operand_i    (operand_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .kind_o       (kind_o),
    .data_o       (data_u),
    .error_code_o (error_code_o),
    .depth_o      (depth_o),
    .last_o       (last_o)
  );

  assign data_o = data_u;

endmodule

// File: tb/sv/tb_rpn_stack_calculator.sv
// tb_rpn_stack_calculator: self-checking testbench for the rpn stack calculator
// depends on rpn_pkg and rpn_stack_calculator; keeps its own stack copy to predict results
// runs directed commands, a random command stream, a back-pressure burst and one error ending

module tb_rpn_stack_calculator;
  import rpn_pkg::*;

  // error endings, one picked per run since only reset clears the halt
  typedef enum int {
    F_POP_EMPTY,
    F_FEW_OPERANDS,
    F_DIV_ZERO,
    F_DUP_EMPTY,
    F_SWAP_FEW,
    F_BAD_ROLL,
    F_INVALID,
    F_FULL_PUSH,
    F_FULL_DUP
  } fault_e;

  localparam logic [OP_W-1:0] OP_FIRST_INVALID = 4'd11;
  localparam logic [OP_W-1:0] OP_LAST_INVALID  = {OP_W{1'b1}};

  typedef struct packed {
    kind_e                    kind;
    logic [DATA_W-1:0]        data;
    err_e                     err;
    logic [DEPTH_OUT_W-1:0]   depth;
    logic                     last;
  } calc_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [OP_W-1:0]          opcode_i;
  logic signed [DATA_W-1:0] operand_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [KIND_W-1:0]        kind_o;
  logic signed [DATA_W-1:0] data_o;
  logic [ERR_W-1:0]         error_code_o;
  logic [DEPTH_OUT_W-1:0]   depth_o;
  logic                     last_o;

  // shadow copy of the calculator
  logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
  int                calc_depth = 0;
  bit                calc_halted = 1'b0;

  calc_result_t pending_results [$];
  int           mismatches = 0;
  int           rx_hold_cycles = 0;
  int           tx_quiet = 0;

  rpn_stack_calculator u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .operand_i    (operand_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .data_o       (data_o),
    .error_code_o (error_code_o),
    .depth_o      (depth_o),
    .last_o       (last_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // safety net for a hung run
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    if (mismatches < 50) begin
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, field, got, want);
    end
    mismatches++;
  endtask

  // signed division, truncating toward zero, wrapping on overflow
  function automatic logic [DATA_W-1:0] quotient_toward_zero(logic [DATA_W-1:0] a,
                                                             logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] ma;
    logic [DATA_W-1:0] mb;
    logic [DATA_W-1:0] q;
    ma = a[DATA_W-1] ? -a : a;
    mb = b[DATA_W-1] ? -b : b;
    q  = ma / mb;
    return (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
  endfunction

  function automatic void owe_result(kind_e kind, logic [DATA_W-1:0] data, err_e err,
                                     logic last);
    calc_result_t r;
    r.kind  = kind;
    r.data  = data;
    r.err   = err;
    r.depth = DEPTH_OUT_W'(calc_depth);
    r.last  = last;
    pending_results.push_back(r);
  endfunction

  function automatic void halt_with(err_e err);
    calc_halted = 1'b1;
    owe_result(KIND_ERROR, '0, err, 1'b1);
  endfunction

  // apply one accepted command to the shadow stack and queue its results
  function automatic void run_command(logic [OP_W-1:0] op, logic [DATA_W-1:0] arg);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] moved;
    int                pos;
    if (calc_halted) begin
      halt_with(ERR_FULL);
      return;
    end
    case (op)
      OP_PUSH: begin
        if (calc_depth >= STACK_DEPTH) begin
          halt_with(ERR_FULL);
          return;
        end
        calc_stack[calc_depth] = arg;
        calc_depth++;
      end
      OP_POP: begin
        if (calc_depth == 0) begin
          halt_with(ERR_POP_EMPTY);
          return;
        end
        calc_depth--;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (calc_depth < 2) begin
          halt_with(ERR_FEW_OPERANDS);
          return;
        end
        b = calc_stack[calc_depth-1];
        a = calc_stack[calc_depth-2];
        if (op == OP_DIV && b == '0) begin
          halt_with(ERR_DIV_ZERO);
          return;
        end
        case (op)
          OP_ADD:  r = a + b;
          OP_SUB:  r = a - b;
          OP_MUL:  r = a * b;
          default: r = quotient_toward_zero(a, b);
        endcase
        calc_depth--;
        calc_stack[calc_depth-1] = r;
      end
      OP_DUP: begin
        if (calc_depth == 0) begin
          halt_with(ERR_DUP_EMPTY);
          return;
        end
        if (calc_depth >= STACK_DEPTH) begin
          halt_with(ERR_FULL);
          return;
        end
        calc_stack[calc_depth] = calc_stack[calc_depth-1];
        calc_depth++;
      end
      OP_SWAP: begin
        if (calc_depth < 2) begin
          halt_with(ERR_SWAP_FEW);
          return;
        end
        r = calc_stack[calc_depth-1];
        calc_stack[calc_depth-1] = calc_stack[calc_depth-2];
        calc_stack[calc_depth-2] = r;
      end
      OP_ROLL: begin
        // a roll by one is a no-op even on an empty stack
        if (arg != 1) begin
          if (arg[DATA_W-1] || arg == '0 || int'(arg) > calc_depth) begin
            halt_with(ERR_BAD_ROLL);
            return;
          end
          pos   = calc_depth - int'(arg);
          moved = calc_stack[pos];
          for (int i = pos; i + 1 < calc_depth; i++) begin
            calc_stack[i] = calc_stack[i+1];
          end
          calc_stack[calc_depth-1] = moved;
        end
      end
      OP_CLEAR: begin
        calc_depth = 0;
      end
      OP_PRINT: begin
        if (calc_depth == 0) begin
          owe_result(KIND_EMPTY, '0, ERR_NONE, 1'b1);
        end else begin
          for (int i = calc_depth; i > 0; i--) begin
            owe_result(KIND_ELEM, calc_stack[i-1], ERR_NONE, i == 1);
          end
        end
        return;
      end
      default: begin
        halt_with(ERR_INVALID);
        return;
      end
    endcase
    owe_result(KIND_DONE, '0, ERR_NONE, 1'b1);
  endfunction

  // sender gaps: mostly none or short, a few long, some quiet stretches
  function automatic int pick_tx_gap();
    int roll;
    if (tx_quiet > 0) begin
      tx_quiet--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      tx_quiet = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // push values: full range, small numbers and the extremes
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 16) - 8;
      1: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          3:       return 32'h0000_0001;
          default: return 32'h0000_0000;
        endcase
      end
      2: return $urandom_range(0, 1000);
      default: return $urandom;
    endcase
  endfunction

  // one command transaction; valid stays high into the next one when there is no gap
  task automatic send_cmd(logic [OP_W-1:0] op, logic [DATA_W-1:0] arg);
    int gap;
    gap = pick_tx_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    operand_i  <= arg;
    do @(posedge clk_i); while (!in_ready_o);
    run_command(op, arg);
  endtask

  // stop offering and let every owed result come back
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // receiver: random stalls, a few long, quiet stretches, and a forced hold-off
  initial begin : rx_side
    int stall_left;
    int quiet_left;
    int roll;
    stall_left  = 0;
    quiet_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_ready_i <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 5) quiet_left = $urandom_range(30, 80);
        else if (roll < 25) stall_left = $urandom_range(1, 3);
        else if (roll < 29) stall_left = $urandom_range(10, 40);
        out_ready_i <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest owed one
  always @(posedge clk_i) begin : check_results
    calc_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing owed", DATA_W'(kind_o), '0);
      end else begin
        want = pending_results.pop_front();
        if (kind_o !== want.kind) begin
          report_mismatch("kind", DATA_W'(kind_o), DATA_W'(want.kind));
        end
        if (data_o !== want.data) report_mismatch("data", data_o, want.data);
        if (error_code_o !== want.err) begin
          report_mismatch("error_code", DATA_W'(error_code_o), DATA_W'(want.err));
        end
        if (depth_o !== want.depth) begin
          report_mismatch("depth", DATA_W'(depth_o), DATA_W'(want.depth));
        end
        if (last_o !== want.last) begin
          report_mismatch("last", DATA_W'(last_o), DATA_W'(want.last));
        end
      end
    end
  end

  // every command, wrapping arithmetic, division corners, rolls and both print forms
  task automatic test_directed();
    send_cmd(OP_ROLL, 32'd1);
    send_cmd(OP_PRINT, 32'hffff_ffff);
    send_cmd(OP_PUSH, 32'h7fff_ffff);
    send_cmd(OP_PUSH, 32'd1);
    send_cmd(OP_ADD, 32'h0);
    send_cmd(OP_PUSH, 32'd1);
    send_cmd(OP_SUB, 32'h5555_5555);
    send_cmd(OP_PUSH, 32'hffff_ffff);
    send_cmd(OP_MUL, 32'haaaa_aaaa);
    send_cmd(OP_PUSH, 32'h8000_0000);
    send_cmd(OP_PUSH, 32'hffff_ffff);
    send_cmd(OP_DIV, 32'h0);
    send_cmd(OP_PUSH, -32'sd7);
    send_cmd(OP_PUSH, 32'd2);
    send_cmd(OP_DIV, 32'h0);
    send_cmd(OP_DUP, 32'h0);
    send_cmd(OP_PUSH, 32'h0);
    send_cmd(OP_SWAP, 32'h0);
    send_cmd(OP_ROLL, 32'd5);
    send_cmd(OP_ROLL, 32'd2);
    send_cmd(OP_PRINT, 32'h0);
    send_cmd(OP_POP, 32'h0);
    send_cmd(OP_CLEAR, 32'h0);
    send_cmd(OP_PRINT, 32'h0);
    wait_results_drained();
  endtask

  // random well-formed command stream that never trips an error
  task automatic test_random_program(int count);
    opcode_e           op;
    logic [DATA_W-1:0] arg;
    bit                ok;
    repeat (count) begin
      op  = opcode_e'($urandom_range(OP_PUSH, OP_PRINT));
      if ($urandom_range(0, 3) == 0) op = OP_PUSH;
      arg = $urandom;
      case (op)
        OP_PUSH:                         ok = calc_depth < STACK_DEPTH;
        OP_POP:                          ok = calc_depth > 0;
        OP_ADD, OP_SUB, OP_MUL, OP_SWAP: ok = calc_depth >= 2;
        OP_DIV:  ok = calc_depth >= 2 && calc_stack[calc_depth-1] != '0;
        OP_DUP:  ok = calc_depth > 0 && calc_depth < STACK_DEPTH;
        OP_ROLL: begin
          ok  = 1'b1;
          arg = (calc_depth > 0) ? $urandom_range(1, calc_depth) : 32'd1;
        end
        OP_CLEAR: ok = $urandom_range(0, 3) == 0;
        default:  ok = 1'b1;
      endcase
      if (!ok) op = (calc_depth < STACK_DEPTH) ? OP_PUSH : OP_POP;
      if (op == OP_PUSH) arg = pick_value();
      send_cmd(op, arg);
    end
    wait_results_drained();
  endtask

  // receiver holds off while the stack is filled, printed and rolled at full depth
  task automatic test_backpressure();
    rx_hold_cycles = 300;
    while (calc_depth < STACK_DEPTH) send_cmd(OP_PUSH, pick_value());
    send_cmd(OP_PRINT, $urandom);
    send_cmd(OP_ROLL, DATA_W'(STACK_DEPTH));
    send_cmd(OP_SWAP, $urandom);
    send_cmd(OP_PRINT, $urandom);
    send_cmd(OP_POP, $urandom);
    wait_results_drained();
  endtask

  // one random error, then commands that must all report the halt
  task automatic test_error_halt();
    fault_e            fault;
    logic [DATA_W-1:0] n;
    fault = fault_e'($urandom_range(F_POP_EMPTY, F_FULL_DUP));
    case (fault)
      F_POP_EMPTY: begin
        send_cmd(OP_CLEAR, $urandom);
        send_cmd(OP_POP, $urandom);
      end
      F_FEW_OPERANDS: begin
        send_cmd(OP_CLEAR, $urandom);
        if ($urandom_range(0, 1) == 1) send_cmd(OP_PUSH, pick_value());
        send_cmd(opcode_e'($urandom_range(OP_ADD, OP_DIV)), $urandom);
      end
      F_DIV_ZERO: begin
        send_cmd(OP_PUSH, pick_value());
        send_cmd(OP_PUSH, '0);
        send_cmd(OP_DIV, $urandom);
      end
      F_DUP_EMPTY: begin
        send_cmd(OP_CLEAR, $urandom);
        send_cmd(OP_DUP, $urandom);
      end
      F_SWAP_FEW: begin
        send_cmd(OP_CLEAR, $urandom);
        if ($urandom_range(0, 1) == 1) send_cmd(OP_PUSH, pick_value());
        send_cmd(OP_SWAP, $urandom);
      end
      F_BAD_ROLL: begin
        case ($urandom_range(0, 2))
          0:       n = '0;
          1:       n = $urandom | 32'h8000_0000;
          default: n = calc_depth + $urandom_range(1, 4);
        endcase
        if (n == 1) n = 32'd2;
        send_cmd(OP_ROLL, n);
      end
      F_INVALID: begin
        send_cmd(OP_W'($urandom_range(OP_FIRST_INVALID, OP_LAST_INVALID)), $urandom);
      end
      default: begin
        while (calc_depth < STACK_DEPTH) send_cmd(OP_PUSH, pick_value());
        send_cmd((fault == F_FULL_PUSH) ? OP_PUSH : OP_DUP, pick_value());
      end
    endcase
    repeat ($urandom_range(3, 5)) begin
      send_cmd(OP_W'($urandom_range(0, OP_LAST_INVALID)), $urandom);
    end
    wait_results_drained();
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    opcode_i   = '0;
    operand_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_program(60);
    test_backpressure();
    test_error_halt();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: rpn_stack_calculator.f
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_div.sv
hw/rtl/rpn_datapath.sv
hw/rtl/rpn_ctrl.sv
hw/rtl/rpn_stack_calculator.sv
tb/sv/tb_rpn_stack_calculator.sv
